### sv/sgd_pkg.sv
package sgd_pkg;

  // Widths fixed by the register map and the result format.
  localparam int COEF_W       = 18;
  localparam int COEF_REGS    = 4;
  localparam int FRAC_BITS    = 16;
  localparam int VALUE_W      = 32;
  localparam int HALF_ORDER_W = 3;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = COEF_W;

  // One stencil coefficient, signed Q1.16.
  typedef logic signed [COEF_W-1:0] coef_t;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HALF_ORDER  = 3'd0,
    REG_COEF_FIRST  = 3'd1,
    REG_COEF_SECOND = 3'd2,
    REG_COEF_THIRD  = 3'd3,
    REG_COEF_FOURTH = 3'd4
  } cfg_reg_t;

endpackage

### sv/staggered_grid_derivative.sv
// Staggered-grid first-derivative stencil along one grid row. Each input item brings the
// next sample and the existing output value of the point that sample completes; once 2m
// samples of the row are held, every item gives one result: the prior value plus the
// rounded sum of a[j]*(x[i+1+j]-x[i-j]) for j below m, saturated to 32 bits and flagged
// when clipped. A row-begin flag in in_tuser restarts the fill. The block takes one item
// every clock cycle while the output is not stalled; a result passes in turn through the
// window register, the product register (one multiplier per coefficient pair) and the
// output register, and each stage holds its item while the stage after it is full.
// Configuration writes are taken at any time but belong only to idle periods.
module staggered_grid_derivative #(
  parameter int MAX_HALF_ORDER = 4,
  parameter int SAMPLE_BITS    = 24,
  localparam int IN_W          = ((SAMPLE_BITS + sgd_pkg::VALUE_W + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input items.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_W-1:0]                    in_tdata,   // sample_in, prior_value
  input  logic                               in_tuser,   // row_begin
  // Result items.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sgd_pkg::VALUE_W-1:0]        out_tdata,  // updated_value
  output logic                               out_tuser,  // clipped
  // Register writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sgd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sgd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WIN_DEPTH = 2 * MAX_HALF_ORDER;
  localparam int M_W       = $clog2(MAX_HALF_ORDER + 1);
  localparam int PROD_W    = sgd_pkg::COEF_W + SAMPLE_BITS + 1;

  logic [sgd_pkg::HALF_ORDER_W-1:0]          half_order_r;
  sgd_pkg::coef_t [sgd_pkg::COEF_REGS-1:0]   coef_r;
  logic [M_W-1:0]                            m_eff;

  logic                                      p1_valid, p1_ready;
  logic [sgd_pkg::VALUE_W-1:0]               p1_prior;
  logic [WIN_DEPTH-1:0][SAMPLE_BITS-1:0]     window;
  logic                                      p2_valid, p2_ready;
  logic [sgd_pkg::VALUE_W-1:0]               p2_prior;
  logic [MAX_HALF_ORDER-1:0][PROD_W-1:0]     p2_prod;

  // Register writes are always accepted; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_order_r <= sgd_pkg::HALF_ORDER_W'(1);
      coef_r       <= '0;
    end else if (cfg_valid) begin
      case (sgd_pkg::cfg_reg_t'(cfg_index))
        sgd_pkg::REG_HALF_ORDER:  half_order_r <= cfg_data[sgd_pkg::HALF_ORDER_W-1:0];
        sgd_pkg::REG_COEF_FIRST:  coef_r[0]    <= cfg_data;
        sgd_pkg::REG_COEF_SECOND: coef_r[1]    <= cfg_data;
        sgd_pkg::REG_COEF_THIRD:  coef_r[2]    <= cfg_data;
        sgd_pkg::REG_COEF_FOURTH: coef_r[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Half order in use: zero counts as one, large values clamp to the window.
  always_comb begin
    if (half_order_r == '0) begin
      m_eff = M_W'(1);
    end else if (int'(half_order_r) > MAX_HALF_ORDER) begin
      m_eff = M_W'(MAX_HALF_ORDER);
    end else begin
      m_eff = M_W'(half_order_r);
    end
  end

  sgd_window #(
    .MAX_HALF_ORDER(MAX_HALF_ORDER),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .in_prior    (in_tdata[SAMPLE_BITS +: sgd_pkg::VALUE_W]),
    .in_row_begin(in_tuser),
    .half_order  (m_eff),
    .nxt_ready   (p1_ready),
    .p1_valid    (p1_valid),
    .p1_prior    (p1_prior),
    .window      (window)
  );

  sgd_mult #(
    .MAX_HALF_ORDER(MAX_HALF_ORDER),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .window    (window),
    .half_order(m_eff),
    .coefs     (coef_r),
    .p1_valid  (p1_valid),
    .p1_prior  (p1_prior),
    .p1_ready  (p1_ready),
    .nxt_ready (p2_ready),
    .p2_valid  (p2_valid),
    .p2_prior  (p2_prior),
    .p2_prod   (p2_prod)
  );

  sgd_accum #(
    .MAX_HALF_ORDER(MAX_HALF_ORDER),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .p2_valid   (p2_valid),
    .p2_prior   (p2_prior),
    .p2_prod    (p2_prod),
    .p2_ready   (p2_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata),
    .out_clipped(out_tuser)
  );

endmodule

### sv/sgd_window.sv
module sgd_window #(
  parameter int MAX_HALF_ORDER = 4,
  parameter int SAMPLE_BITS    = 24,
  localparam int WIN_DEPTH     = 2 * MAX_HALF_ORDER,
  localparam int M_W           = $clog2(MAX_HALF_ORDER + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [SAMPLE_BITS-1:0]                in_sample,
  input  logic [sgd_pkg::VALUE_W-1:0]           in_prior,
  input  logic                                  in_row_begin,
  input  logic [M_W-1:0]                        half_order,
  input  logic                                  nxt_ready,
  output logic                                  p1_valid,
  output logic [sgd_pkg::VALUE_W-1:0]           p1_prior,
  output logic [WIN_DEPTH-1:0][SAMPLE_BITS-1:0] window
);

  localparam int FILL_W = $clog2(WIN_DEPTH + 1);

  logic [WIN_DEPTH-1:0][SAMPLE_BITS-1:0] win_r, win_nxt;
  logic [FILL_W-1:0]                     fill_r, fill_nxt;
  logic                                  valid_r, valid_nxt;
  logic [sgd_pkg::VALUE_W-1:0]           prior_r;
  logic                                  accept;
  logic [FILL_W-1:0]                     fill_base;
  logic                                  produce;

  // A new item may enter whenever the held one leaves in the same cycle.
  assign in_ready = !valid_r || nxt_ready;
  assign accept   = in_valid && in_ready;

  // Shift the new sample in at the low end of the window.
  always_comb begin
    win_nxt[0] = in_sample;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // Fill count restarts at a row start and saturates at the window depth.
  always_comb begin
    fill_base = in_row_begin ? '0 : fill_r;
    fill_nxt  = fill_base;
    if (int'(fill_base) < WIN_DEPTH) begin
      fill_nxt = fill_base + FILL_W'(1);
    end
    produce = int'(fill_nxt) >= 2 * int'(half_order);
  end

  // The held item stays until the product stage takes it.
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = produce;
    end else if (nxt_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // Sample taps and the prior value carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r   <= win_nxt;
      prior_r <= in_prior;
    end
  end

  assign p1_valid = valid_r;
  assign p1_prior = prior_r;
  assign window   = win_r;

endmodule

### sv/sgd_mult.sv
module sgd_mult #(
  parameter int MAX_HALF_ORDER = 4,
  parameter int SAMPLE_BITS    = 24,
  localparam int WIN_DEPTH     = 2 * MAX_HALF_ORDER,
  localparam int M_W           = $clog2(MAX_HALF_ORDER + 1),
  localparam int PROD_W        = sgd_pkg::COEF_W + SAMPLE_BITS + 1
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic [WIN_DEPTH-1:0][SAMPLE_BITS-1:0]        window,
  input  logic [M_W-1:0]                               half_order,
  input  sgd_pkg::coef_t [sgd_pkg::COEF_REGS-1:0]      coefs,
  input  logic                                         p1_valid,
  input  logic [sgd_pkg::VALUE_W-1:0]                  p1_prior,
  output logic                                         p1_ready,
  input  logic                                         nxt_ready,
  output logic                                         p2_valid,
  output logic [sgd_pkg::VALUE_W-1:0]                  p2_prior,
  output logic [MAX_HALF_ORDER-1:0][PROD_W-1:0]        p2_prod
);

  logic                                  valid_r;
  logic [sgd_pkg::VALUE_W-1:0]           prior_r;
  logic [MAX_HALF_ORDER-1:0][PROD_W-1:0] prod_r, prod_nxt;
  logic                                  load;

  assign p1_ready = !valid_r || nxt_ready;
  assign load     = p1_valid && p1_ready;

  // One lane per coefficient pair: tap difference, then one multiply.
  for (genvar j = 0; j < MAX_HALF_ORDER; j++) begin : g_lane
    if (j < sgd_pkg::COEF_REGS) begin : g_coef
      logic signed [SAMPLE_BITS:0] diff;

      // The tap pair moves outward with the half order.
      always_comb begin
        diff = '0;
        for (int k = j + 1; k <= MAX_HALF_ORDER; k++) begin
          if (half_order == M_W'(k)) begin
            diff = $signed({window[k-1-j][SAMPLE_BITS-1], window[k-1-j]})
                 - $signed({window[k+j][SAMPLE_BITS-1], window[k+j]});
          end
        end
      end

      assign prod_nxt[j] = PROD_W'($signed(coefs[j]) * diff);
    end else begin : g_zero
      // Pairs beyond the coefficient registers contribute nothing.
      assign prod_nxt[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (p1_ready) begin
      valid_r <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r  <= prod_nxt;
      prior_r <= p1_prior;
    end
  end

  assign p2_valid = valid_r;
  assign p2_prior = prior_r;
  assign p2_prod  = prod_r;

endmodule

### sv/sgd_accum.sv
module sgd_accum #(
  parameter int MAX_HALF_ORDER = 4,
  parameter int SAMPLE_BITS    = 24,
  localparam int PROD_W        = sgd_pkg::COEF_W + SAMPLE_BITS + 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  p2_valid,
  input  logic [sgd_pkg::VALUE_W-1:0]           p2_prior,
  input  logic [MAX_HALF_ORDER-1:0][PROD_W-1:0] p2_prod,
  output logic                                  p2_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sgd_pkg::VALUE_W-1:0]           out_value,
  output logic                                  out_clipped
);

  localparam int ACC_W = PROD_W + $clog2(MAX_HALF_ORDER) + 1;
  localparam int SUM_W = ACC_W + 1;
  localparam int VW    = sgd_pkg::VALUE_W;

  logic                    valid_r;
  logic [VW-1:0]           value_r, value_nxt;
  logic                    clip_r, clip_nxt;
  logic signed [ACC_W-1:0] acc, rounded;
  logic signed [SUM_W-1:0] total;
  logic                    load;

  assign p2_ready = !valid_r || out_ready;
  assign load     = p2_valid && p2_ready;

  // Sum the lane products exactly in Q.16.
  always_comb begin
    acc = '0;
    for (int j = 0; j < MAX_HALF_ORDER; j++) begin
      acc = acc + ACC_W'($signed(p2_prod[j]));
    end
  end

  // Round to nearest with ties upward, add the prior value, then saturate.
  always_comb begin
    rounded = (acc + ACC_W'(1 << (sgd_pkg::FRAC_BITS - 1))) >>> sgd_pkg::FRAC_BITS;
    total   = SUM_W'(rounded) + SUM_W'($signed(p2_prior));
    if (total[SUM_W-1:VW-1] == '0 || total[SUM_W-1:VW-1] == '1) begin
      value_nxt = total[VW-1:0];
      clip_nxt  = 1'b0;
    end else begin
      value_nxt = total[SUM_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      clip_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (p2_ready) begin
      valid_r <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= value_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_value   = value_r;
  assign out_clipped = clip_r;

endmodule

### verif/tb_staggered_grid_derivative.sv
module tb_staggered_grid_derivative;

  localparam int MAX_HALF_ORDER  = 4;
  localparam int SAMPLE_BITS     = 24;
  localparam int WINDOW_DEPTH    = 2 * MAX_HALF_ORDER;
  localparam int IN_W            = ((SAMPLE_BITS + sgd_pkg::VALUE_W + 7) / 8) * 8;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int QUIET_PHASE     = 4;
  localparam int SETTLE_CYCLES   = 8;
  localparam int QUIET_LIMIT     = 1000;

  // Register indexes past the end of the map; writes to them must be ignored.
  localparam logic [sgd_pkg::CFG_INDEX_W-1:0] REG_BEYOND_FIRST = 3'd5;
  localparam logic [sgd_pkg::CFG_INDEX_W-1:0] REG_BEYOND_LAST  = 3'd7;

  typedef logic signed [SAMPLE_BITS-1:0]      sample_t;
  typedef logic signed [sgd_pkg::VALUE_W-1:0] value_t;

  localparam sample_t        X_MAX      = 24'sh7FFFFF;
  localparam sample_t        X_MIN      = 24'sh800000;
  localparam value_t         P_MAX      = 32'sh7FFFFFFF;
  localparam value_t         P_MIN      = 32'sh80000000;
  localparam sgd_pkg::coef_t C_MAX      = 18'sh1FFFF;
  localparam sgd_pkg::coef_t C_MIN      = 18'sh20000;
  localparam longint         SUM_MAX    = 64'sd2147483647;
  localparam longint         SUM_MIN    = -64'sd2147483648;
  localparam longint         ROUND_HALF = 64'sd1 <<< (sgd_pkg::FRAC_BITS - 1);

  typedef struct packed {
    logic [sgd_pkg::VALUE_W-1:0] value;
    logic                        clip;
  } result_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;
  typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_GIVEN} check_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [sgd_pkg::CFG_INDEX_W-1:0] index;
    logic [sgd_pkg::CFG_DATA_W-1:0]  data;
    logic [SAMPLE_BITS-1:0]          x;
    logic [sgd_pkg::VALUE_W-1:0]     prior;
    logic                            row_begin;
    check_t                          check;
    result_t                         want;
  } step_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [IN_W-1:0]                 in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [sgd_pkg::VALUE_W-1:0]     out_tdata;
  logic                            out_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [sgd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sgd_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Mirror of the block's registers and row state.
  logic [sgd_pkg::HALF_ORDER_W-1:0] order_reg = 3'd1;
  sgd_pkg::coef_t                   coef_reg [sgd_pkg::COEF_REGS];
  sample_t                          window [WINDOW_DEPTH];
  int                               fill = 0;

  result_t expected_updates [$];
  result_t want_result;
  step_t   steps [$];
  int      mismatch_count = 0;
  int      quiet_cycles = 0;
  bit      no_idle = 1'b0;
  bit      streaming = 1'b0;

  staggered_grid_derivative #(
    .MAX_HALF_ORDER(MAX_HALF_ORDER),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shift one sample into the row window and, once 2m samples are held, form the
  // updated value of the point just completed.
  function automatic bit derive_point(input sample_t x, input value_t prior,
                                      input logic row_begin, output result_t res);
    int     m;
    int     k;
    longint acc;
    longint total;
    m = int'(order_reg);
    if (m < 1) m = 1;
    if (m > MAX_HALF_ORDER) m = MAX_HALF_ORDER;
    if (row_begin) fill = 0;
    for (k = WINDOW_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = x;
    if (fill < WINDOW_DEPTH) fill++;
    res = '0;
    if (fill < 2 * m) return 1'b0;
    acc = 0;
    for (k = 0; k < m; k++) begin
      acc += longint'(coef_reg[k]) * (longint'(window[m-1-k]) - longint'(window[m+k]));
    end
    // Round to nearest, ties toward plus infinity, then saturate.
    total = longint'(prior) + ((acc + ROUND_HALF) >>> sgd_pkg::FRAC_BITS);
    if (total > SUM_MAX) begin
      total = SUM_MAX;
      res.clip = 1'b1;
    end else if (total < SUM_MIN) begin
      total = SUM_MIN;
      res.clip = 1'b1;
    end
    res.value = total[sgd_pkg::VALUE_W-1:0];
    return 1'b1;
  endfunction

  function automatic step_t write_row(input logic [sgd_pkg::CFG_INDEX_W-1:0] index,
                                      input logic [sgd_pkg::CFG_DATA_W-1:0] data);
    step_t s;
    s = '0;
    s.kind = ROW_WRITE;
    s.index = index;
    s.data = data;
    return s;
  endfunction

  function automatic step_t item_row(input sample_t x, input value_t prior,
                                     input logic row_begin, input check_t check,
                                     input value_t value = '0, input logic clip = 1'b0);
    step_t s;
    s = '0;
    s.kind = ROW_ITEM;
    s.x = x;
    s.prior = prior;
    s.row_begin = row_begin;
    s.check = check;
    s.want = {value, clip};
    return s;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [sgd_pkg::VALUE_W-1:0] got,
                                 input logic [sgd_pkg::VALUE_W-1:0] want);
    $display("mismatch at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Write one register and update the mirror. The valid stays high on return so
  // that back-to-back writes need no gap; the caller lowers it after the batch.
  task automatic write_reg(input logic [sgd_pkg::CFG_INDEX_W-1:0] index,
                           input logic [sgd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      sgd_pkg::REG_HALF_ORDER: order_reg = data[sgd_pkg::HALF_ORDER_W-1:0];
      sgd_pkg::REG_COEF_FIRST, sgd_pkg::REG_COEF_SECOND, sgd_pkg::REG_COEF_THIRD,
      sgd_pkg::REG_COEF_FOURTH:
        coef_reg[2'(index - sgd_pkg::REG_COEF_FIRST)] = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Offer one item after an optional random gap and record what it should produce.
  task automatic send_item(input sample_t x, input value_t prior, input logic row_begin,
                           input check_t check, input result_t given);
    result_t predicted;
    bit      produced;
    while (!no_idle && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({prior, x});
    in_tuser  <= row_begin;
    do @(posedge clk); while (!in_tready);
    produced = derive_point(x, prior, row_begin, predicted);
    case (check)
      CHECK_MODEL: if (produced) expected_updates.push_back(predicted);
      CHECK_GIVEN: expected_updates.push_back(given);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Stop sending and let the pipeline empty, including items that give no result.
  task automatic settle_pipeline();
    in_tvalid <= 1'b0;
    while (expected_updates.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: random back-pressure.
  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 19);
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_updates.size() == 0) begin
        report_mismatch("result with none expected", out_tdata, '0);
      end else begin
        want_result = expected_updates.pop_front();
        if (out_tdata !== want_result.value)
          report_mismatch("updated_value", out_tdata, want_result.value);
        if (out_tuser !== want_result.clip)
          report_mismatch("clipped", sgd_pkg::VALUE_W'(out_tuser),
                          sgd_pkg::VALUE_W'(want_result.clip));
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("staggered_grid_derivative test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int             i;
    int             phase;
    int             n;
    int             r;
    sgd_pkg::coef_t c;
    sample_t        x;
    value_t         prior;
    logic           rb;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    for (i = 0; i < sgd_pkg::COEF_REGS; i++) coef_reg[i] = '0;
    for (i = 0; i < WINDOW_DEPTH; i++) window[i] = '0;

    // Directed rows. Reset values first: m of one and zero coefficients.
    steps.push_back(item_row(24'sd0, 32'sd0, 1'b1, CHECK_NONE));
    steps.push_back(item_row(24'sd5, 32'sd1234, 1'b0, CHECK_GIVEN, 32'sd1234, 1'b0));
    // Full-scale coefficients and samples drive the sum into saturation both ways.
    steps.push_back(write_row(sgd_pkg::REG_COEF_FIRST, C_MAX));
    steps.push_back(write_row(sgd_pkg::REG_COEF_SECOND, C_MIN));
    steps.push_back(item_row(X_MIN, 32'sd0, 1'b1, CHECK_NONE));
    steps.push_back(item_row(X_MAX, P_MAX, 1'b0, CHECK_GIVEN, P_MAX, 1'b1));
    steps.push_back(item_row(X_MIN, P_MIN, 1'b0, CHECK_GIVEN, P_MIN, 1'b1));
    steps.push_back(item_row(24'sd0, 32'sd0, 1'b0, CHECK_MODEL));
    steps.push_back(item_row(-24'sd1, -32'sd1, 1'b0, CHECK_MODEL));
    // Half order zero acts as one; a unit coefficient exposes the rounding ties.
    steps.push_back(write_row(sgd_pkg::REG_HALF_ORDER, 18'd0));
    steps.push_back(write_row(sgd_pkg::REG_COEF_FIRST, 18'd1));
    steps.push_back(item_row(24'sd0, 32'sd0, 1'b0, CHECK_MODEL));
    steps.push_back(item_row(24'sd32768, 32'sd0, 1'b0, CHECK_GIVEN, 32'sd1, 1'b0));
    steps.push_back(item_row(24'sd0, 32'sd0, 1'b0, CHECK_GIVEN, 32'sd0, 1'b0));
    // Widest stencil, switched in mid-row on a window that is already full.
    steps.push_back(write_row(sgd_pkg::REG_HALF_ORDER, 18'd4));
    steps.push_back(write_row(sgd_pkg::REG_COEF_FIRST, 18'h0C000));
    steps.push_back(write_row(sgd_pkg::REG_COEF_SECOND, 18'h3F555));
    steps.push_back(write_row(sgd_pkg::REG_COEF_THIRD, 18'h00AAA));
    steps.push_back(write_row(sgd_pkg::REG_COEF_FOURTH, C_MAX));
    steps.push_back(write_row(REG_BEYOND_FIRST, 18'h3FFFF));
    steps.push_back(write_row(REG_BEYOND_LAST, 18'h2AAAA));
    steps.push_back(item_row(24'sd1000, 32'sd100, 1'b0, CHECK_MODEL));
    steps.push_back(item_row(-24'sd300000, -32'sd5, 1'b0, CHECK_MODEL));
    // A new row must refill all eight samples before the next result.
    steps.push_back(item_row(24'sd777, 32'sd0, 1'b1, CHECK_NONE));
    for (i = 1; i < WINDOW_DEPTH - 1; i++)
      steps.push_back(item_row(sample_t'(i * 1111), 32'sd0, 1'b0, CHECK_NONE));
    steps.push_back(item_row(X_MAX, 32'sd42, 1'b0, CHECK_MODEL));
    // Half order above the maximum is clamped; upper data bits are don't-care.
    steps.push_back(write_row(sgd_pkg::REG_HALF_ORDER, 18'd7));
    steps.push_back(item_row(X_MIN, 32'sd0, 1'b0, CHECK_MODEL));
    steps.push_back(write_row(sgd_pkg::REG_HALF_ORDER, 18'h3FFFA));
    steps.push_back(item_row(24'sd123456, P_MAX, 1'b0, CHECK_MODEL));
    steps.push_back(item_row(-24'sd654321, P_MIN, 1'b0, CHECK_MODEL));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_WRITE) begin
        if (streaming) settle_pipeline();
        streaming = 1'b0;
        write_reg(steps[i].index, steps[i].data);
      end else begin
        cfg_valid <= 1'b0;
        streaming = 1'b1;
        send_item(steps[i].x, steps[i].prior, steps[i].row_begin, steps[i].check,
                  steps[i].want);
      end
    end

    // Random phases, each with a fresh register setting written while idle.
    for (phase = 0; phase < PHASES; phase++) begin
      settle_pipeline();
      no_idle = (phase == QUIET_PHASE);
      write_reg(sgd_pkg::REG_HALF_ORDER, {15'($urandom), 3'($urandom_range(7))});
      for (r = 0; r < sgd_pkg::COEF_REGS; r++) begin
        case ($urandom_range(3))
          0: c = C_MAX;
          1: c = C_MIN;
          2: c = sgd_pkg::coef_t'($urandom_range(4000)) - sgd_pkg::coef_t'(2000);
          default: c = sgd_pkg::coef_t'($urandom);
        endcase
        write_reg(sgd_pkg::CFG_INDEX_W'(sgd_pkg::REG_COEF_FIRST + r), c);
      end
      write_reg(sgd_pkg::CFG_INDEX_W'($urandom_range(REG_BEYOND_LAST, REG_BEYOND_FIRST)),
                sgd_pkg::CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(7))
          0: x = X_MAX;
          1: x = X_MIN;
          2: x = sample_t'($urandom_range(2000)) - sample_t'(1000);
          default: x = sample_t'($urandom);
        endcase
        case ($urandom_range(7))
          0: prior = P_MAX;
          1: prior = P_MIN;
          default: prior = value_t'($urandom);
        endcase
        rb = (n == 0) ? 1'($urandom) : ($urandom_range(15) == 0);
        send_item(x, prior, rb, CHECK_MODEL, '0);
      end
    end
    no_idle = 1'b0;

    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("staggered_grid_derivative test passed");
    end else begin
      $display("staggered_grid_derivative test failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/sgd_pkg.sv
sv/sgd_window.sv
sv/sgd_mult.sv
sv/sgd_accum.sv
sv/staggered_grid_derivative.sv
verif/tb_staggered_grid_derivative.sv
